// ===== rtl/core/gmec_pkg.sv =====
// Shared constants, types and state codes for the greedy mesh element coloring block.
package gmec_pkg;

	// Node memory geometry: node numbers index the memory directly
	localparam int NODE_DEPTH        = 16384;
	localparam int NODE_W            = 14;
	localparam int NODE_AW           = $clog2(NODE_DEPTH);

	// Color set
	localparam int MAX_COLORS        = 32;
	localparam int COLOR_W           = 5;
	localparam int TOTAL_W           = 6;

	// Element shape
	localparam int NODES_PER_ELEMENT = 8;
	localparam int CNT_W             = 4;
	localparam int KW                = $clog2(NODES_PER_ELEMENT);
	localparam int IDX_W             = 16;

	// Operation codes
	localparam logic OP_COLOR = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Node memory access request
	typedef struct packed {
		logic                  we;
		logic [NODE_AW-1:0]    addr;
		logic [MAX_COLORS-1:0] wdata;
	} ram_req_t;

	// Sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CLEAR = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_PICK  = 7'b0010000,
		ST_WRITE = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

endpackage

// ===== rtl/core/gmec_mask_ram.sv =====
// Single-port node color mask memory with registered read data.
module gmec_mask_ram (
	input  logic                           clk,
	input  gmec_pkg::ram_req_t             req,
	output logic [gmec_pkg::MAX_COLORS-1:0] rd_data
);

	logic [gmec_pkg::MAX_COLORS-1:0] mem [gmec_pkg::NODE_DEPTH];
	logic [gmec_pkg::MAX_COLORS-1:0] rd_data_q;

	// Read one word per cycle, and also write one word when req.we is set
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rd_data_q <= mem[req.addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/gmec_pick.sv =====
// Blocked-color accumulator and lowest-free-color encoder.
module gmec_pick (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clr,
	input  logic                             acc_en,
	input  logic [gmec_pkg::MAX_COLORS-1:0]  acc_mask,
	input  logic                             eval,
	output logic [gmec_pkg::COLOR_W-1:0]     color,
	output logic                             overflow
);

	logic [gmec_pkg::MAX_COLORS-1:0] blocked_q;
	logic [gmec_pkg::MAX_COLORS-1:0] free_set;
	logic [gmec_pkg::MAX_COLORS-1:0] low_bit;
	logic [gmec_pkg::COLOR_W-1:0]    enc;
	logic [gmec_pkg::COLOR_W-1:0]    color_q;
	logic                            overflow_q;

	// Accumulate the OR of the node masks of one element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= '0;
		end else if (clr) begin
			blocked_q <= '0;
		end else if (acc_en) begin
			blocked_q <= blocked_q | acc_mask;
		end
	end

	// Isolate the lowest free color and encode it
	assign free_set = ~blocked_q;
	assign low_bit  = free_set & (~free_set + gmec_pkg::MAX_COLORS'(1));

	always_comb begin
		enc = '0;
		for (int b = 0; b < gmec_pkg::MAX_COLORS; b++) begin
			if (low_bit[b]) begin
				enc = enc | gmec_pkg::COLOR_W'(b);
			end
		end
	end

	// Hold the chosen color; saturate when every color is blocked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q    <= '0;
			overflow_q <= 1'b0;
		end else if (eval) begin
			overflow_q <= (free_set == '0);
			color_q    <= (free_set == '0) ? gmec_pkg::COLOR_W'(gmec_pkg::MAX_COLORS - 1) : enc;
		end
	end

	assign color    = color_q;
	assign overflow = overflow_q;

endmodule

// ===== rtl/core/greedy_mesh_element_coloring.sv =====
// Top level: sequencer for greedy element coloring over a shared node mask memory.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+--------------------------
//  command   | op, node_count, node_a .. node_h              | start & !busy
//  result    | element_index, color, colors_used,            | done, one cycle,
//            | color_overflow                                | no back-pressure
//
// A color command with n nodes (n = node_count, saturated to 8) holds busy high while
// the single memory port reads each node mask once and writes it back once. With no
// node nothing is read or written; when every color is blocked the write-back is skipped.
// After reset and after each clear command all 16384 memory words are swept, one word
// a cycle, with busy high. The receiver cannot stall; done lasts one cycle.
module greedy_mesh_element_coloring (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [gmec_pkg::CNT_W-1:0]        node_count,
	input  logic [gmec_pkg::NODE_W-1:0]       node_a,
	input  logic [gmec_pkg::NODE_W-1:0]       node_b,
	input  logic [gmec_pkg::NODE_W-1:0]       node_c,
	input  logic [gmec_pkg::NODE_W-1:0]       node_d,
	input  logic [gmec_pkg::NODE_W-1:0]       node_e,
	input  logic [gmec_pkg::NODE_W-1:0]       node_f,
	input  logic [gmec_pkg::NODE_W-1:0]       node_g,
	input  logic [gmec_pkg::NODE_W-1:0]       node_h,
	output logic                              done,
	output logic [gmec_pkg::IDX_W-1:0]        element_index,
	output logic [gmec_pkg::COLOR_W-1:0]      color,
	output logic [gmec_pkg::TOTAL_W-1:0]      colors_used,
	output logic                              color_overflow
);

	gmec_pkg::state_t   state_q;
	gmec_pkg::ram_req_t ram_req;

	logic [gmec_pkg::NODE_W-1:0]     node_q [gmec_pkg::NODES_PER_ELEMENT];
	logic [gmec_pkg::MAX_COLORS-1:0] mask_q [gmec_pkg::NODES_PER_ELEMENT];
	logic [gmec_pkg::CNT_W-1:0]      cnt_q;
	logic [gmec_pkg::CNT_W-1:0]      k_q;
	logic [gmec_pkg::KW-1:0]         k_idx;
	logic [gmec_pkg::NODE_AW-1:0]    clr_addr_q;
	logic                            rd_vld_s1;
	logic [gmec_pkg::KW-1:0]         rd_k_s1;
	logic [gmec_pkg::MAX_COLORS-1:0] rd_data;
	logic [gmec_pkg::IDX_W-1:0]      elem_q;
	logic [gmec_pkg::TOTAL_W-1:0]    total_q;
	logic [gmec_pkg::COLOR_W-1:0]    pick_color;
	logic                            pick_ovf;
	logic [gmec_pkg::TOTAL_W-1:0]    next_total;
	logic [gmec_pkg::MAX_COLORS-1:0] color_bit;
	logic                            accept;
	logic                            k_last;
	logic                            write_skip;
	logic                            write_done;

	logic [gmec_pkg::NODE_W-1:0]     node_in [gmec_pkg::NODES_PER_ELEMENT];

	assign node_in[0] = node_a;
	assign node_in[1] = node_b;
	assign node_in[2] = node_c;
	assign node_in[3] = node_d;
	assign node_in[4] = node_e;
	assign node_in[5] = node_f;
	assign node_in[6] = node_g;
	assign node_in[7] = node_h;

	assign busy       = (state_q != gmec_pkg::ST_IDLE);
	assign accept     = start && !busy;
	assign k_idx      = k_q[gmec_pkg::KW-1:0];
	assign k_last     = (k_q == cnt_q - gmec_pkg::CNT_W'(1));
	assign write_skip = pick_ovf || (cnt_q == '0);
	assign write_done = (state_q == gmec_pkg::ST_WRITE) && (write_skip || k_last);
	assign color_bit  = gmec_pkg::MAX_COLORS'(1) << pick_color;
	assign next_total = gmec_pkg::TOTAL_W'(pick_color) + gmec_pkg::TOTAL_W'(1);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gmec_pkg::ST_CLEAR;
			clr_addr_q <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			elem_q     <= '0;
			total_q    <= '0;
		end else begin
			unique case (state_q)
				gmec_pkg::ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						if (op == gmec_pkg::OP_CLEAR) begin
							elem_q     <= '0;
							total_q    <= '0;
							clr_addr_q <= '0;
							state_q    <= gmec_pkg::ST_CLEAR;
						end else begin
							if (node_count > gmec_pkg::CNT_W'(gmec_pkg::NODES_PER_ELEMENT)) begin
								cnt_q <= gmec_pkg::CNT_W'(gmec_pkg::NODES_PER_ELEMENT);
							end else begin
								cnt_q <= node_count;
							end
							state_q <= (node_count == '0) ? gmec_pkg::ST_PICK : gmec_pkg::ST_READ;
						end
					end
				end
				gmec_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + gmec_pkg::NODE_AW'(1);
					if (clr_addr_q == gmec_pkg::NODE_AW'(gmec_pkg::NODE_DEPTH - 1)) begin
						state_q <= gmec_pkg::ST_IDLE;
					end
				end
				gmec_pkg::ST_READ: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= gmec_pkg::ST_DRAIN;
					end else begin
						k_q <= k_q + gmec_pkg::CNT_W'(1);
					end
				end
				gmec_pkg::ST_DRAIN: begin
					state_q <= gmec_pkg::ST_PICK;
				end
				gmec_pkg::ST_PICK: begin
					state_q <= gmec_pkg::ST_WRITE;
				end
				gmec_pkg::ST_WRITE: begin
					if (write_done) begin
						k_q     <= '0;
						elem_q  <= elem_q + gmec_pkg::IDX_W'(1);
						state_q <= gmec_pkg::ST_DONE;
						if (!pick_ovf && (next_total > total_q)) begin
							total_q <= next_total;
						end
					end else begin
						k_q <= k_q + gmec_pkg::CNT_W'(1);
					end
				end
				gmec_pkg::ST_DONE: begin
					state_q <= gmec_pkg::ST_IDLE;
				end
				default: begin
					state_q <= gmec_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Capture node numbers of an accepted element
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < gmec_pkg::NODES_PER_ELEMENT; i++) begin
				node_q[i] <= node_in[i];
			end
		end
	end

	// Track which read word returns next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_k_s1   <= '0;
		end else begin
			rd_vld_s1 <= (state_q == gmec_pkg::ST_READ);
			rd_k_s1   <= k_idx;
		end
	end

	// Keep each node's mask for the write-back
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			mask_q[rd_k_s1] <= rd_data;
		end
	end

	// Drive the memory port
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.addr  = node_q[k_idx][gmec_pkg::NODE_AW-1:0];
		ram_req.wdata = mask_q[k_idx] | color_bit;
		priority case (1'b1)
			(state_q == gmec_pkg::ST_CLEAR): begin
				ram_req.we    = 1'b1;
				ram_req.addr  = clr_addr_q;
				ram_req.wdata = '0;
			end
			(state_q == gmec_pkg::ST_WRITE): begin
				ram_req.we = !write_skip;
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	gmec_mask_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	gmec_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (accept),
		.acc_en   (rd_vld_s1),
		.acc_mask (rd_data),
		.eval     (state_q == gmec_pkg::ST_PICK),
		.color    (pick_color),
		.overflow (pick_ovf)
	);

	// Register the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= write_done;
		end
	end

	always_ff @(posedge clk) begin
		if (write_done) begin
			element_index  <= elem_q;
			color          <= pick_color;
			color_overflow <= pick_ovf;
			colors_used    <= (!pick_ovf && (next_total > total_q)) ? next_total : total_q;
		end
	end

endmodule
